// ----- src/sccbw_pkg.sv -----
`timescale 1ns / 1ps

package sccbw_pkg;

   localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'h42;
   localparam logic [7:0] MAX_ATTEMPTS_RESET   = 8'd200;
   localparam logic [7:0] ATTEMPT_LIMIT        = 8'hFF;

   typedef enum logic [0:0] {
      CSR_DEVICE_ADDRESS = 1'b0,
      CSR_MAX_ATTEMPTS   = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      FUNC_TICK    = 1'b0,
      FUNC_REQUEST = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      BYTE_DEVICE  = 2'd0,
      BYTE_ADDRESS = 2'd1,
      BYTE_DATA    = 2'd2
   } byte_sel_type;

   typedef enum logic [3:0] {
      PH_IDLE = 4'd0,
      PH_ST0  = 4'd1,
      PH_ST1  = 4'd2,
      PH_ST2  = 4'd3,
      PH_BD   = 4'd4,
      PH_BH   = 4'd5,
      PH_BL   = 4'd6,
      PH_AR   = 4'd7,
      PH_AH   = 4'd8,
      PH_AL   = 4'd9,
      PH_SP0  = 4'd10,
      PH_SP1  = 4'd11,
      PH_SP2  = 4'd12
   } phase_type;

   typedef struct packed {
      logic scl_level;
      logic sda_level;
      logic sda_release;
      logic busy_res;
      logic done_res;
      logic failed;
   } bus_result_type;

endpackage

// ----- src/sccbw_seq.sv -----
`timescale 1ns / 1ps

module sccbw_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic                     func,
   input  logic [7:0]               reg_address,
   input  logic [7:0]               write_data,
   input  logic                     sda_sample,
   input  logic [7:0]               device_address,
   input  logic [7:0]               max_attempts,
   output sccbw_pkg::bus_result_type result
);

   sccbw_pkg::phase_type phase_ff, phase_in;
   logic [2:0] bit_index_ff, bit_index_in;
   logic [1:0] byte_index_ff, byte_index_in;
   logic [7:0] shift_byte_ff, shift_byte_in;
   logic [7:0] attempt_count_ff, attempt_count_in;
   logic [7:0] latched_address_ff, latched_address_in;
   logic [7:0] latched_data_ff, latched_data_in;
   logic       last_nack_ff, last_nack_in;
   logic       done, fail;
   logic [7:0] attempt_next;
   logic [1:0] byte_next;

   function automatic logic [7:0] byte_for(input logic [1:0] idx, input logic [7:0] dev,
                                           input logic [7:0] adr, input logic [7:0] dat);
      logic [7:0] sel;
      unique case (idx)
         sccbw_pkg::BYTE_DEVICE:  sel = dev;
         sccbw_pkg::BYTE_ADDRESS: sel = adr;
         default:                 sel = dat;
      endcase
      return sel;
   endfunction

   assign attempt_next = (attempt_count_ff == sccbw_pkg::ATTEMPT_LIMIT) ?
                         attempt_count_ff : attempt_count_ff + 8'd1;
   assign byte_next    = byte_index_ff + 2'd1;

   always_comb begin
      phase_in           = phase_ff;
      bit_index_in       = bit_index_ff;
      byte_index_in      = byte_index_ff;
      shift_byte_in      = shift_byte_ff;
      attempt_count_in   = attempt_count_ff;
      latched_address_in = latched_address_ff;
      latched_data_in    = latched_data_ff;
      last_nack_in       = last_nack_ff;
      done               = 1'b0;
      fail               = 1'b0;
      if (func == sccbw_pkg::FUNC_REQUEST) begin
         if (phase_ff == sccbw_pkg::PH_IDLE) begin
            latched_address_in = reg_address;
            latched_data_in    = write_data;
            attempt_count_in   = 8'd0;
            phase_in           = sccbw_pkg::PH_ST0;
            bit_index_in       = 3'd0;
            byte_index_in      = 2'd0;
            last_nack_in       = 1'b0;
         end
      end else begin
         unique case (phase_ff)
            sccbw_pkg::PH_ST0: phase_in = sccbw_pkg::PH_ST1;
            sccbw_pkg::PH_ST1: phase_in = sccbw_pkg::PH_ST2;
            sccbw_pkg::PH_ST2: begin
               byte_index_in = 2'd0;
               bit_index_in  = 3'd0;
               shift_byte_in = device_address;
               phase_in      = sccbw_pkg::PH_BD;
            end
            sccbw_pkg::PH_BD: phase_in = sccbw_pkg::PH_BH;
            sccbw_pkg::PH_BH: phase_in = sccbw_pkg::PH_BL;
            sccbw_pkg::PH_BL: begin
               shift_byte_in = {shift_byte_ff[6:0], 1'b0};
               if (bit_index_ff == 3'd7) begin
                  bit_index_in = 3'd0;
                  phase_in     = sccbw_pkg::PH_AR;
               end else begin
                  bit_index_in = bit_index_ff + 3'd1;
                  phase_in     = sccbw_pkg::PH_BD;
               end
            end
            sccbw_pkg::PH_AR: phase_in = sccbw_pkg::PH_AH;
            sccbw_pkg::PH_AH: begin
               last_nack_in = sda_sample;
               phase_in     = sccbw_pkg::PH_AL;
            end
            sccbw_pkg::PH_AL: begin
               if (last_nack_ff || byte_index_ff >= sccbw_pkg::BYTE_DATA) begin
                  phase_in = sccbw_pkg::PH_SP0;
               end else begin
                  byte_index_in = byte_next;
                  bit_index_in  = 3'd0;
                  shift_byte_in = byte_for(byte_next, device_address,
                                           latched_address_ff, latched_data_ff);
                  phase_in      = sccbw_pkg::PH_BD;
               end
            end
            sccbw_pkg::PH_SP0: phase_in = sccbw_pkg::PH_SP1;
            sccbw_pkg::PH_SP1: phase_in = sccbw_pkg::PH_SP2;
            sccbw_pkg::PH_SP2: begin
               if (last_nack_ff) begin
                  attempt_count_in = attempt_next;
                  if (attempt_next >= max_attempts) begin
                     done     = 1'b1;
                     fail     = 1'b1;
                     phase_in = sccbw_pkg::PH_IDLE;
                  end else begin
                     phase_in      = sccbw_pkg::PH_ST0;
                     bit_index_in  = 3'd0;
                     byte_index_in = 2'd0;
                     last_nack_in  = 1'b0;
                  end
               end else begin
                  done     = 1'b1;
                  phase_in = sccbw_pkg::PH_IDLE;
               end
            end
            default: phase_in = sccbw_pkg::PH_IDLE;
         endcase
      end
   end

   always_comb begin
      result             = '0;
      result.scl_level   = 1'b1;
      result.sda_level   = 1'b1;
      result.sda_release = 1'b0;
      unique case (phase_in)
         sccbw_pkg::PH_ST1: result.sda_level = 1'b0;
         sccbw_pkg::PH_ST2: begin
            result.scl_level = 1'b0;
            result.sda_level = 1'b0;
         end
         sccbw_pkg::PH_BD, sccbw_pkg::PH_BL: begin
            result.scl_level = 1'b0;
            result.sda_level = shift_byte_in[7];
         end
         sccbw_pkg::PH_BH: result.sda_level = shift_byte_in[7];
         sccbw_pkg::PH_AR, sccbw_pkg::PH_AL: begin
            result.scl_level   = 1'b0;
            result.sda_release = 1'b1;
         end
         sccbw_pkg::PH_AH: result.sda_release = 1'b1;
         sccbw_pkg::PH_SP0: begin
            result.scl_level = 1'b0;
            result.sda_level = 1'b0;
         end
         sccbw_pkg::PH_SP1: result.sda_level = 1'b0;
         default: ;
      endcase
      result.busy_res = (phase_in != sccbw_pkg::PH_IDLE);
      result.done_res = done;
      result.failed   = fail;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sccbw_pkg::PH_IDLE;
      end else if (step) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         bit_index_ff       <= bit_index_in;
         byte_index_ff      <= byte_index_in;
         shift_byte_ff      <= shift_byte_in;
         attempt_count_ff   <= attempt_count_in;
         latched_address_ff <= latched_address_in;
         latched_data_ff    <= latched_data_in;
         last_nack_ff       <= last_nack_in;
      end
   end

   a_hold_without_beat: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff))
      else $error("phase moved without an input beat");

   a_request_while_busy: assert property (@(posedge clock) disable iff (reset)
      step && func && phase_ff != sccbw_pkg::PH_IDLE |=> phase_ff == $past(phase_ff))
      else $error("request while busy changed the phase");

   a_ack_sample: assert property (@(posedge clock) disable iff (reset)
      step && !func && phase_ff == sccbw_pkg::PH_AH |=> phase_ff == sccbw_pkg::PH_AL)
      else $error("acknowledge sample did not advance to ack low");

   a_last_bit: assert property (@(posedge clock) disable iff (reset)
      step && !func && phase_ff == sccbw_pkg::PH_BL && bit_index_ff == 3'd7
      |=> phase_ff == sccbw_pkg::PH_AR)
      else $error("eighth bit did not lead to acknowledge");

   a_fail_needs_done: assert property (@(posedge clock) disable iff (reset)
      result.failed |-> result.done_res && !result.busy_res)
      else $error("failed without done or while busy");

endmodule

// ----- src/sccb_write_master_retry.sv -----
`timescale 1ns / 1ps

// SCCB write master with retry, one bus waveform step per input beat.
// Input channel req_*: req_func = 1 is a write request (register address and
// data byte), taken only while idle; a request while busy is absorbed with no
// effect. req_func = 0 is a timing tick that advances SCL/SDA by one step;
// req_sda_sample is the sampled SDA line, used at the acknowledge bit.
// Result channel rsp_*: exactly one beat per input beat, in order, giving the
// SCL/SDA levels, SDA release, busy, and done/failed on the finishing tick.
// A nacked byte sends stop and restarts; after max_attempts failures the
// sequence ends with failed set.
// A result beat appears in the cycle after its input beat, one beat per cycle
// while not stalled; the single result register is the only stage between the
// channels. When rsp_stall is high with a result held, req_stall rises and the
// input waits; the result register holds its beat unchanged.
// csr_*: index 0 is device_address (reset 0x42), index 1 max_attempts
// (reset 200); write only while idle.
// Reset (synchronous, active high) returns the sequencer to idle, empties the
// result register and restores both configuration registers.

module sccb_write_master_retry (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_func,
   input  logic [7:0] req_reg_address,
   input  logic [7:0] req_write_data,
   input  logic       req_sda_sample,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_scl_level,
   output logic       rsp_sda_level,
   output logic       rsp_sda_release,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic       rsp_failed,
   input  logic       csr_write_enable,
   input  logic [0:0] csr_index,
   input  logic [7:0] csr_data
);

   logic       step;
   logic [7:0] device_address_ff;
   logic [7:0] max_attempts_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   sccbw_pkg::bus_result_type result;
   sccbw_pkg::bus_result_type rsp_ff;

   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign step         = req_valid && !req_stall;
   assign rsp_valid_in = step || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= sccbw_pkg::DEVICE_ADDRESS_RESET;
         max_attempts_ff   <= sccbw_pkg::MAX_ATTEMPTS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            sccbw_pkg::CSR_DEVICE_ADDRESS: device_address_ff <= csr_data;
            sccbw_pkg::CSR_MAX_ATTEMPTS:   max_attempts_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   sccbw_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .func           (req_func),
      .reg_address    (req_reg_address),
      .write_data     (req_write_data),
      .sda_sample     (req_sda_sample),
      .device_address (device_address_ff),
      .max_attempts   (max_attempts_ff),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_scl_level   = rsp_ff.scl_level;
   assign rsp_sda_level   = rsp_ff.sda_level;
   assign rsp_sda_release = rsp_ff.sda_release;
   assign rsp_busy_res    = rsp_ff.busy_res;
   assign rsp_done_res    = rsp_ff.done_res;
   assign rsp_failed      = rsp_ff.failed;

   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !step)
      else $error("input beat taken while result register is blocked");

   a_beat_fills_output: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("input beat produced no result beat");

   a_release_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.sda_release |-> rsp_ff.sda_level && rsp_ff.busy_res)
      else $error("released SDA not shown high or shown while idle");

endmodule
